>>> src/usg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usg_pkg
// Shared types, constants and fixed-point helpers of the UV sphere generator.
// ----------------------------------------------------------------------------
package usg_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_W        = 7;
    localparam int RAD_W        = 16;
    localparam int IDX_W        = 13;
    localparam int PHASE_W      = 32;
    localparam int DIV_STEPS    = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int XY_W         = 34;   // CORDIC x/y, Q30 with headroom
    localparam int Z_W          = 33;   // residual angle, 2^-32 turn units
    localparam int POS_W        = 17;
    localparam int NORM_W       = 16;
    localparam int WIDE_W       = 68;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [SEG_W-1:0] SEG_RESET = 7'd36;
    localparam logic [RAD_W-1:0] RAD_RESET = 16'd256;

    // configuration register indexes
    localparam logic REG_SEGMENT_COUNT = 1'b0;
    localparam logic REG_SPHERE_RADIUS = 1'b1;

    typedef enum logic [1:0] {
        KIND_VERTEX    = 2'd0,
        KIND_TRIANGLE  = 2'd1,
        KIND_RANGE_ERR = 2'd2
    } kind_t;

    typedef struct packed {
        logic             oor;
        logic             tri_a;
        logic             tri_b;
        logic [IDX_W-1:0] k1;
        logic [IDX_W-1:0] k2;
    } info_t;

    typedef struct packed {
        logic [SEG_W-1:0]   rem_u;
        logic [PHASE_W-1:0] quo_u;
        logic               wrap_u;
        logic [SEG_W-1:0]   rem_v;
        logic [PHASE_W-1:0] quo_v;
        info_t              info;
    } div_t;

    typedef struct packed {
        logic signed [XY_W-1:0] xu;
        logic signed [XY_W-1:0] yu;
        logic signed [Z_W-1:0]  zu;
        logic [1:0]             qu;
        logic signed [XY_W-1:0] xv;
        logic signed [XY_W-1:0] yv;
        logic signed [Z_W-1:0]  zv;
        logic [1:0]             qv;
        info_t                  info;
    } cor_t;

    // atan(2^-k) in 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_turn(input logic [3:0] k);
        case (k)
            4'd0:    return 33'sd536870912;
            4'd1:    return 33'sd316933406;
            4'd2:    return 33'sd167458907;
            4'd3:    return 33'sd85004756;
            4'd4:    return 33'sd42667331;
            4'd5:    return 33'sd21354465;
            4'd6:    return 33'sd10679838;
            4'd7:    return 33'sd5340245;
            4'd8:    return 33'sd2670163;
            4'd9:    return 33'sd1335087;
            4'd10:   return 33'sd667544;
            4'd11:   return 33'sd333772;
            4'd12:   return 33'sd166886;
            4'd13:   return 33'sd83443;
            4'd14:   return 33'sd41722;
            4'd15:   return 33'sd20861;
            default: return 33'sd0;
        endcase
    endfunction

    // round to nearest, tie toward +inf
    function automatic logic signed [WIDE_W-1:0] rnd_shr(input logic signed [WIDE_W-1:0] v,
                                                         input int unsigned s);
        logic signed [WIDE_W:0] t;
        t = (WIDE_W+1)'(v) + ((69'sd1) <<< (s - 1));
        return WIDE_W'(t >>> s);
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        if (v > 68'sd65535)
            return 17'sd65535;
        else if (v < -68'sd65535)
            return -17'sd65535;
        else
            return POS_W'(v);
    endfunction

    function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [WIDE_W-1:0] v);
        if (v > 68'sd32767)
            return 16'sd32767;
        else if (v < -68'sd32768)
            return -16'sd32768;
        else
            return NORM_W'(v);
    endfunction

endpackage

>>> src/uv_sphere_vertex_and_index_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_and_index_generator
// UV sphere grid point to vertex, normal and triangle indices.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (stack_index, sector_index) enter on in_valid/in_ready. Each
//   request yields its vertex, then up to two triangles, on out_valid/
//   out_ready; last_of_run marks the final result of a request. An index
//   past the segment count yields a single range-error result.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 segment count, 1 radius); write only while the block is idle.
// Pipeline:
//   The first result reaches the outputs through 53 register stages:
//   32 division cells, 16 CORDIC cells, 4 scaling stages and the output
//   register.
//   A new request can enter every cycle while in_ready is high; a request
//   makes 1 to 3 results and holds the chain until the single result port
//   has sent its last one.
// Reset: segment count 36, radius 1.0, pipeline empty.
// Stall: while the output register holds a result that is not taken or not
//   the last of its request, the whole cell chain holds, and in_ready drops.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_and_index_generator
    import usg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [RAD_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SEG_W-1:0]         stack_index,
    input  logic [SEG_W-1:0]         sector_index,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               result_kind,
    output logic signed [POS_W-1:0]  pos_x,
    output logic signed [POS_W-1:0]  pos_y,
    output logic signed [POS_W-1:0]  pos_z,
    output logic signed [NORM_W-1:0] norm_x,
    output logic signed [NORM_W-1:0] norm_y,
    output logic signed [NORM_W-1:0] norm_z,
    output logic [IDX_W-1:0]         corner_a,
    output logic [IDX_W-1:0]         corner_b,
    output logic [IDX_W-1:0]         corner_c,
    output logic                     last_of_run
);

    typedef enum logic [1:0] {
        EM_VERTEX,
        EM_TRI_A,
        EM_TRI_B,
        EM_RANGE
    } em_state_t;

    logic [SEG_W-1:0]        seg_count_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic [SEG_W-1:0]        segs;
    logic                    adv;

    div_t                    front;
    logic                    div_v [0:DIV_STEPS];
    div_t                    div_d [0:DIV_STEPS];
    logic                    cor_v [0:CORDIC_STEPS];
    cor_t                    cor_d [0:CORDIC_STEPS];

    logic [PHASE_W-1:0]      phase_u, phase_v;
    logic signed [XY_W-1:0]  cu, su, cv, sv;

    logic                    post_valid;
    info_t                   post_info;
    logic signed [POS_W-1:0] post_px, post_py, post_pz;
    logic signed [NORM_W-1:0] post_nx, post_ny, post_nz;

    logic                    em_valid_reg;
    em_state_t               em_state_reg;
    info_t                   em_info_reg;
    logic signed [POS_W-1:0] em_px_reg, em_py_reg, em_pz_reg;
    logic signed [NORM_W-1:0] em_nx_reg, em_ny_reg, em_nz_reg;
    logic                    em_last;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= SEG_RESET;
            radius_reg    <= RAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEGMENT_COUNT: seg_count_reg <= cfg_data[SEG_W-1:0];
                REG_SPHERE_RADIUS: radius_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (seg_count_reg == '0)
            segs = SEG_W'(1);
        else if (seg_count_reg > SEG_W'(MAX_SEGMENTS))
            segs = SEG_W'(MAX_SEGMENTS);
        else
            segs = seg_count_reg;
    end

    // front: index checks, vertex indices, division seed
    always_comb
    begin
        front            = '0;
        front.info.oor   = (stack_index > segs) || (sector_index > segs);
        front.info.k1    = IDX_W'(stack_index) * (IDX_W'(segs) + IDX_W'(1))
                           + IDX_W'(sector_index);
        front.info.k2    = front.info.k1 + IDX_W'(segs) + IDX_W'(1);
        front.info.tri_a = (stack_index < segs) && (sector_index < segs)
                           && (stack_index != '0);
        front.info.tri_b = (stack_index < segs) && (sector_index < segs)
                           && (stack_index != segs - SEG_W'(1));
        // index == S is a full turn: remainder restarts at zero
        front.wrap_u     = (stack_index == segs);
        front.rem_u      = (stack_index == segs) ? '0 : stack_index;
        front.rem_v      = (sector_index == segs) ? '0 : sector_index;
    end

    assign div_v[0] = in_valid;
    assign div_d[0] = front;

    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++)
        begin : g_div
            usg_div_cell u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .seg       (segs),
                .in_valid  (div_v[g]),
                .in_data   (div_d[g]),
                .out_valid (div_v[g+1]),
                .out_data  (div_d[g+1])
            );
        end
    endgenerate

    // phases into CORDIC seeds
    assign phase_v = div_d[DIV_STEPS].quo_v;
    assign phase_u = 32'h4000_0000
                     - {div_d[DIV_STEPS].wrap_u, div_d[DIV_STEPS].quo_u[PHASE_W-1:1]};

    always_comb
    begin
        logic [PHASE_W-1:0] du, dv;
        cor_d[0]      = '0;
        cor_d[0].info = div_d[DIV_STEPS].info;
        cor_d[0].qu   = 2'((phase_u + 32'h2000_0000) >> 30);
        cor_d[0].qv   = 2'((phase_v + 32'h2000_0000) >> 30);
        du            = phase_u - {cor_d[0].qu, 30'b0};
        dv            = phase_v - {cor_d[0].qv, 30'b0};
        cor_d[0].zu   = $signed({du[PHASE_W-1], du});
        cor_d[0].zv   = $signed({dv[PHASE_W-1], dv});
        cor_d[0].xu   = CORDIC_GAIN;
        cor_d[0].xv   = CORDIC_GAIN;
    end

    assign cor_v[0] = div_v[DIV_STEPS];

    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_cor
            usg_cordic_cell u_cor (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .step      (4'(g)),
                .in_valid  (cor_v[g]),
                .in_data   (cor_d[g]),
                .out_valid (cor_v[g+1]),
                .out_data  (cor_d[g+1])
            );
        end
    endgenerate

    // quadrant turn: (c,s), (-s,c), (-c,-s), (s,-c)
    always_comb
    begin
        case (cor_d[CORDIC_STEPS].qu)
            2'd0:    begin cu =  cor_d[CORDIC_STEPS].xu; su =  cor_d[CORDIC_STEPS].yu; end
            2'd1:    begin cu = -cor_d[CORDIC_STEPS].yu; su =  cor_d[CORDIC_STEPS].xu; end
            2'd2:    begin cu = -cor_d[CORDIC_STEPS].xu; su = -cor_d[CORDIC_STEPS].yu; end
            default: begin cu =  cor_d[CORDIC_STEPS].yu; su = -cor_d[CORDIC_STEPS].xu; end
        endcase
        case (cor_d[CORDIC_STEPS].qv)
            2'd0:    begin cv =  cor_d[CORDIC_STEPS].xv; sv =  cor_d[CORDIC_STEPS].yv; end
            2'd1:    begin cv = -cor_d[CORDIC_STEPS].yv; sv =  cor_d[CORDIC_STEPS].xv; end
            2'd2:    begin cv = -cor_d[CORDIC_STEPS].xv; sv = -cor_d[CORDIC_STEPS].yv; end
            default: begin cv =  cor_d[CORDIC_STEPS].yv; sv = -cor_d[CORDIC_STEPS].xv; end
        endcase
    end

    usg_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .radius    (radius_reg),
        .in_valid  (cor_v[CORDIC_STEPS]),
        .in_info   (cor_d[CORDIC_STEPS].info),
        .cu        (cu),
        .su        (su),
        .cv        (cv),
        .sv        (sv),
        .out_valid (post_valid),
        .out_info  (post_info),
        .px        (post_px),
        .py        (post_py),
        .pz        (post_pz),
        .nx        (post_nx),
        .ny        (post_ny),
        .nz        (post_nz)
    );

    // output register and result sequencer
    always_comb
    begin
        case (em_state_reg)
            EM_VERTEX: em_last = !em_info_reg.tri_a && !em_info_reg.tri_b;
            EM_TRI_A:  em_last = !em_info_reg.tri_b;
            default:   em_last = 1'b1;
        endcase
    end

    assign adv      = !em_valid_reg || (out_ready && em_last);
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            em_state_reg <= EM_VERTEX;
        end
        else if (adv)
        begin
            em_valid_reg <= post_valid;
            em_state_reg <= post_info.oor ? EM_RANGE : EM_VERTEX;
        end
        else if (out_ready)
        begin
            case (em_state_reg)
                EM_VERTEX: em_state_reg <= em_info_reg.tri_a ? EM_TRI_A : EM_TRI_B;
                EM_TRI_A:  em_state_reg <= EM_TRI_B;
                default:   em_state_reg <= em_state_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            em_info_reg <= post_info;
            em_px_reg   <= post_px;
            em_py_reg   <= post_py;
            em_pz_reg   <= post_pz;
            em_nx_reg   <= post_nx;
            em_ny_reg   <= post_ny;
            em_nz_reg   <= post_nz;
        end
    end

    always_comb
    begin
        result_kind = KIND_VERTEX;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        norm_x      = '0;
        norm_y      = '0;
        norm_z      = '0;
        corner_a    = '0;
        corner_b    = '0;
        corner_c    = '0;
        case (em_state_reg)
            EM_VERTEX:
            begin
                pos_x    = em_px_reg;
                pos_y    = em_py_reg;
                pos_z    = em_pz_reg;
                norm_x   = em_nx_reg;
                norm_y   = em_ny_reg;
                norm_z   = em_nz_reg;
                corner_a = em_info_reg.k1;
            end
            EM_TRI_A:
            begin
                result_kind = KIND_TRIANGLE;
                corner_a    = em_info_reg.k1;
                corner_b    = em_info_reg.k2;
                corner_c    = em_info_reg.k1 + IDX_W'(1);
            end
            EM_TRI_B:
            begin
                result_kind = KIND_TRIANGLE;
                corner_a    = em_info_reg.k1 + IDX_W'(1);
                corner_b    = em_info_reg.k2;
                corner_c    = em_info_reg.k2 + IDX_W'(1);
            end
            default:
            begin
                result_kind = KIND_RANGE_ERR;
            end
        endcase
    end

    assign out_valid   = em_valid_reg;
    assign last_of_run = em_last;

endmodule

>>> src/usg_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usg_div_cell
// One restoring-division step for the stack and sector phases.
// ----------------------------------------------------------------------------
module usg_div_cell
    import usg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [SEG_W-1:0] seg,
    input  logic             in_valid,
    input  div_t             in_data,
    output logic             out_valid,
    output div_t             out_data
);

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [SEG_W:0]   tu;
    logic [SEG_W:0]   tv;
    logic             ge_u;
    logic             ge_v;

    always_comb
    begin
        tu   = {in_data.rem_u, 1'b0};
        tv   = {in_data.rem_v, 1'b0};
        ge_u = tu >= {1'b0, seg};
        ge_v = tv >= {1'b0, seg};
        data_next       = in_data;
        data_next.rem_u = ge_u ? SEG_W'(tu - {1'b0, seg}) : tu[SEG_W-1:0];
        data_next.rem_v = ge_v ? SEG_W'(tv - {1'b0, seg}) : tv[SEG_W-1:0];
        data_next.quo_u = {in_data.quo_u[PHASE_W-2:0], ge_u};
        data_next.quo_v = {in_data.quo_v[PHASE_W-2:0], ge_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/usg_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usg_cordic_cell
// One rotation-mode CORDIC iteration for the stack and sector angles.
// ----------------------------------------------------------------------------
module usg_cordic_cell
    import usg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [3:0] step,
    input  logic       in_valid,
    input  cor_t       in_data,
    output logic       out_valid,
    output cor_t       out_data
);

    logic                   valid_reg;
    cor_t                   data_reg;
    cor_t                   data_next;
    logic signed [Z_W-1:0]  ang;

    always_comb
    begin
        ang       = atan_turn(step);
        data_next = in_data;
        if (!in_data.zu[Z_W-1])
        begin
            data_next.xu = in_data.xu - (in_data.yu >>> step);
            data_next.yu = in_data.yu + (in_data.xu >>> step);
            data_next.zu = in_data.zu - ang;
        end
        else
        begin
            data_next.xu = in_data.xu + (in_data.yu >>> step);
            data_next.yu = in_data.yu - (in_data.xu >>> step);
            data_next.zu = in_data.zu + ang;
        end
        if (!in_data.zv[Z_W-1])
        begin
            data_next.xv = in_data.xv - (in_data.yv >>> step);
            data_next.yv = in_data.yv + (in_data.xv >>> step);
            data_next.zv = in_data.zv - ang;
        end
        else
        begin
            data_next.xv = in_data.xv + (in_data.yv >>> step);
            data_next.yv = in_data.yv - (in_data.xv >>> step);
            data_next.zv = in_data.zv + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/usg_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usg_post
// Scales sine/cosine into position (Q8.8) and normal (Q1.15), four stages.
// ----------------------------------------------------------------------------
module usg_post
    import usg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [RAD_W-1:0]         radius,
    input  logic                     in_valid,
    input  info_t                    in_info,
    input  logic signed [XY_W-1:0]   cu,
    input  logic signed [XY_W-1:0]   su,
    input  logic signed [XY_W-1:0]   cv,
    input  logic signed [XY_W-1:0]   sv,
    output logic                     out_valid,
    output info_t                    out_info,
    output logic signed [POS_W-1:0]  px,
    output logic signed [POS_W-1:0]  py,
    output logic signed [POS_W-1:0]  pz,
    output logic signed [NORM_W-1:0] nx,
    output logic signed [NORM_W-1:0] ny,
    output logic signed [NORM_W-1:0] nz
);

    logic [3:0]                   valid_reg;
    info_t                        info1_reg, info2_reg, info3_reg, info4_reg;
    // stage 1: products
    logic signed [50:0]           rcu_reg, rsu_reg;
    logic signed [WIDE_W-1:0]     cc_reg, cs_reg;
    logic signed [XY_W-1:0]       cv1_reg, sv1_reg;
    logic signed [NORM_W-1:0]     nz1_reg;
    // stage 2: rounded
    logic signed [POS_W-1:0]      xy2_reg, z2_reg;
    logic signed [XY_W-1:0]       cv2_reg, sv2_reg;
    logic signed [NORM_W-1:0]     nx2_reg, ny2_reg, nz2_reg;
    // stage 3: xy products
    logic signed [50:0]           px3_reg, py3_reg;
    logic signed [POS_W-1:0]      z3_reg;
    logic signed [NORM_W-1:0]     nx3_reg, ny3_reg, nz3_reg;
    // stage 4: final
    logic signed [POS_W-1:0]      px4_reg, py4_reg, z4_reg;
    logic signed [NORM_W-1:0]     nx4_reg, ny4_reg, nz4_reg;
    logic signed [POS_W-1:0]      rad_s;

    assign rad_s = $signed({1'b0, radius});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            info1_reg <= in_info;
            rcu_reg   <= rad_s * cu;
            rsu_reg   <= rad_s * su;
            cc_reg    <= cu * cv;
            cs_reg    <= cu * sv;
            cv1_reg   <= cv;
            sv1_reg   <= sv;
            nz1_reg   <= sat_norm(rnd_shr(WIDE_W'(su), 15));

            info2_reg <= info1_reg;
            xy2_reg   <= sat_pos(rnd_shr(WIDE_W'(rcu_reg), 30));
            z2_reg    <= sat_pos(rnd_shr(WIDE_W'(rsu_reg), 30));
            nx2_reg   <= sat_norm(rnd_shr(cc_reg, 45));
            ny2_reg   <= sat_norm(rnd_shr(cs_reg, 45));
            nz2_reg   <= nz1_reg;
            cv2_reg   <= cv1_reg;
            sv2_reg   <= sv1_reg;

            info3_reg <= info2_reg;
            px3_reg   <= xy2_reg * cv2_reg;
            py3_reg   <= xy2_reg * sv2_reg;
            z3_reg    <= z2_reg;
            nx3_reg   <= nx2_reg;
            ny3_reg   <= ny2_reg;
            nz3_reg   <= nz2_reg;

            info4_reg <= info3_reg;
            px4_reg   <= sat_pos(rnd_shr(WIDE_W'(px3_reg), 30));
            py4_reg   <= sat_pos(rnd_shr(WIDE_W'(py3_reg), 30));
            z4_reg    <= z3_reg;
            nx4_reg   <= nx3_reg;
            ny4_reg   <= ny3_reg;
            nz4_reg   <= nz3_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_info  = info4_reg;
    assign px        = px4_reg;
    assign py        = py4_reg;
    assign pz        = z4_reg;
    assign nx        = nx4_reg;
    assign ny        = ny4_reg;
    assign nz        = nz4_reg;

endmodule

>>> src/usg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usg_checker
// Port-level checks of the UV sphere generator, bound to the top level.
// ----------------------------------------------------------------------------
module usg_checker
    import usg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [1:0]               result_kind,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [NORM_W-1:0] norm_x,
    input  logic [IDX_W-1:0]         corner_a,
    input  logic [IDX_W-1:0]         corner_b,
    input  logic [IDX_W-1:0]         corner_c,
    input  logic                     last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_RANGE_ERR |-> last_of_run && corner_a == '0)
        else $error("range error result malformed");

    a_tri_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_TRIANGLE |->
            corner_b > corner_a && (corner_c == corner_a + 1'b1 || corner_c == corner_b + 1'b1)
            && pos_x == '0 && norm_x == '0)
        else $error("triangle corners inconsistent");

    a_vertex_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_VERTEX |-> corner_b == '0 && corner_c == '0)
        else $error("vertex result carries triangle corners");

endmodule

bind uv_sphere_vertex_and_index_generator usg_checker u_usg_checker (.*);
